// ===== rtl/mvt_pkg.sv =====
`default_nettype none
package mvt_pkg;

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned PROD_W     = 2 * DATA_W;
  localparam int unsigned SUM_W      = PROD_W + 2;
  localparam int unsigned DIM        = 4;
  localparam int unsigned NUM_REGS   = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned LATENCY    = 5;

  typedef logic signed [DATA_W-1:0] q_t;
  typedef q_t [DIM-1:0] vec_t;
  typedef vec_t [DIM-1:0] mat_t;
  typedef logic [CFG_DATA_W-1:0] cfg_word_t;

  localparam q_t Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam q_t Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

endpackage
`default_nettype wire

// ===== rtl/mvt_matrix_regs.sv =====
`default_nettype none
module mvt_matrix_regs
  import mvt_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire cfg_word_t            cfg_data,
  output mat_t                      mat
);

  localparam logic [DATA_W-1:0] ONE = DATA_W'(1) << FRAC_BITS;

  cfg_word_t regs [NUM_REGS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_REGS; k++) begin
        regs[k] <= {(2 * (k % 2) + 1 == k / 2) ? ONE : {DATA_W{1'b0}},
                    (2 * (k % 2) == k / 2) ? ONE : {DATA_W{1'b0}}};
      end
    end else if (cfg_we) begin
      regs[cfg_index] <= cfg_data;
    end
  end

  for (genvar r = 0; r < DIM; r++) begin : g_row
    for (genvar c = 0; c < DIM; c++) begin : g_col
      assign mat[r][c] = q_t'(regs[2 * r + c / 2][DATA_W * (c % 2) +: DATA_W]);
    end
  end

  // identity right after reset
  a_reset_identity: assert property (@(posedge clk)
    $past(rst) && !rst |-> (mat[0][0] == q_t'(ONE)) && (mat[1][1] == q_t'(ONE)) &&
                   (mat[2][2] == q_t'(ONE)) && (mat[3][3] == q_t'(ONE)) &&
                   (mat[0][1] == '0) && (mat[3][2] == '0))
    else $error("matrix not identity after reset");

endmodule
`default_nettype wire

// ===== rtl/mvt_dot_lane.sv =====
`default_nettype none
module mvt_dot_lane
  import mvt_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic clk,
  input  wire vec_t vec,
  input  wire vec_t row,
  output q_t        res
);

  logic signed [PROD_W-1:0]  prod [DIM];
  logic signed [PROD_W:0]    pair [2];
  logic signed [SUM_W-1:0]   sum;
  logic signed [SUM_W-1:0]   shifted;
  q_t                        sat;

  always_comb begin
    shifted = sum >>> FRAC_BITS;
    if (&shifted[SUM_W-1:DATA_W-1] || ~|shifted[SUM_W-1:DATA_W-1]) begin
      sat = q_t'(shifted[DATA_W-1:0]);
    end else begin
      sat = sum[SUM_W-1] ? Q_MIN : Q_MAX;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < DIM; j++) begin
      prod[j] <= row[j] * vec[j];
    end
    pair[0] <= (PROD_W+1)'(prod[0]) + (PROD_W+1)'(prod[1]);
    pair[1] <= (PROD_W+1)'(prod[2]) + (PROD_W+1)'(prod[3]);
    sum     <= SUM_W'(pair[0]) + SUM_W'(pair[1]);
    res     <= sat;
  end

endmodule
`default_nettype wire

// ===== rtl/matrix4_vector_transform.sv =====
`default_nettype none
// Transforms one 4-component signed Q16.16 vector per clock by the 4x4 matrix held in
// the eight configuration registers (identity after reset). A vector is taken whenever
// start is high; busy is always low. Each result appears for one cycle with done high
// and must be captured then: the receiver cannot stall the block. Each vector passes
// through the input register, the 32x32 multiplier stage, two adder-tree stages and
// the shift/saturate output register. Write the matrix only while no vector
// is in flight.
module matrix4_vector_transform
  import mvt_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire q_t                   in_x,
  input  wire q_t                   in_y,
  input  wire q_t                   in_z,
  input  wire q_t                   in_w,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire cfg_word_t            cfg_data,
  output logic                      done,
  output q_t                        out_x,
  output q_t                        out_y,
  output q_t                        out_z,
  output q_t                        out_w
);

  mat_t                 mat;
  vec_t                 vec;
  vec_t                 res;
  logic [LATENCY-1:0]   valid;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    vec <= {in_w, in_z, in_y, in_x};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[LATENCY-2:0], start};
    end
  end

  mvt_matrix_regs #(.FRAC_BITS(FRAC_BITS)) u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mat       (mat)
  );

  for (genvar i = 0; i < DIM; i++) begin : g_lane
    mvt_dot_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk (clk),
      .vec (vec),
      .row (mat[i]),
      .res (res[i])
    );
  end

  assign done  = valid[LATENCY-1];
  assign out_x = res[0];
  assign out_y = res[1];
  assign out_z = res[2];
  assign out_w = res[3];

  a_item_done: assert property (@(posedge clk) disable iff (rst)
    start |-> ##5 done)
    else $error("accepted item produced no result");

  a_done_had_item: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 5))
    else $error("result without accepted item");

  a_never_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(done) |-> !busy && $past(valid[LATENCY-2]))
    else $error("result strobe out of step with pipeline");

endmodule
`default_nettype wire

// ===== tb/sv/matrix4_vector_transform_tb.sv =====
`default_nettype none
module matrix4_vector_transform_tb;
  import mvt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRAC_BITS = 16;
  localparam q_t Q_ONE = q_t'(1 << FRAC_BITS);
  localparam int DRAIN_LIMIT = 1000;
  localparam int MISMATCH_SHOWN = 10;
  localparam int RANDOM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 70;

  typedef enum int {
    MAT_IDENTITY,
    MAT_TINY,
    MAT_MAX,
    MAT_MIN,
    MAT_MIXED,
    MAT_SCALE,
    MAT_RANDOM
  } mat_kind_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  q_t in_x = '0;
  q_t in_y = '0;
  q_t in_z = '0;
  q_t in_w = '0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  cfg_word_t cfg_data = '0;
  logic done;
  q_t out_x;
  q_t out_y;
  q_t out_z;
  q_t out_w;

  matrix4_vector_transform #(
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .in_x(in_x),
    .in_y(in_y),
    .in_z(in_z),
    .in_w(in_w),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .done(done),
    .out_x(out_x),
    .out_y(out_y),
    .out_z(out_z),
    .out_w(out_w)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // matrix as the block should hold it, identity after reset
  cfg_word_t matrix_regs [NUM_REGS] = '{
    cfg_word_t'(Q_ONE), '0, cfg_word_t'(Q_ONE) << 32, '0,
    '0, cfg_word_t'(Q_ONE), '0, cfg_word_t'(Q_ONE) << 32
  };

  vec_t pending_vectors [$];
  vec_t expected_vectors [$];
  int queued_count = 0;
  int accepted_count = 0;
  int error_count = 0;
  int burst_left = 0;
  int gap_left = 0;
  bit bursty = 1'b0;
  string field_name [DIM] = '{"out_x", "out_y", "out_z", "out_w"};

  function automatic vec_t transform_vector(input vec_t v);
    vec_t res;
    q_t coef;
    q_t comp;
    logic signed [SUM_W-1:0] acc;
    logic signed [SUM_W-1:0] term;
    logic signed [SUM_W-1:0] scaled;
    for (int i = 0; i < DIM; i++) begin
      acc = '0;
      for (int j = 0; j < DIM; j++) begin
        coef = matrix_regs[2*i + j/2][DATA_W*(j%2) +: DATA_W];
        comp = v[j];
        term = coef * comp;
        acc = acc + term;
      end
      scaled = acc >>> FRAC_BITS;
      if (&scaled[SUM_W-1:DATA_W-1] || !(|scaled[SUM_W-1:DATA_W-1])) begin
        res[i] = scaled[DATA_W-1:0];
      end else if (scaled[SUM_W-1]) begin
        res[i] = Q_MIN;
      end else begin
        res[i] = Q_MAX;
      end
    end
    return res;
  endfunction

  function automatic q_t random_component();
    int unsigned pick;
    pick = $urandom_range(99, 0);
    if (pick < 25) begin
      return q_t'($urandom);
    end else if (pick < 60) begin
      return q_t'($urandom_range(32'h0020_0000, 0) - 32'h0010_0000);
    end else if (pick < 88) begin
      return q_t'($urandom_range(32'h0200_0000, 0) - 32'h0100_0000);
    end else begin
      case ($urandom_range(4, 0))
        0: return Q_MAX;
        1: return Q_MIN;
        2: return '0;
        3: return '1;
        default: return Q_ONE;
      endcase
    end
  endfunction

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= MISMATCH_SHOWN) begin
      $display("mismatch at %0t: %s", $realtime, msg);
    end
  endtask

  task automatic queue_xyzw(input q_t x, input q_t y, input q_t z, input q_t w);
    pending_vectors.push_back({w, z, y, x});
    queued_count++;
  endtask

  task automatic load_matrix(input mat_kind_t kind);
    cfg_word_t staged [NUM_REGS];
    q_t ent;
    for (int i = 0; i < DIM; i++) begin
      for (int j = 0; j < DIM; j++) begin
        case (kind)
          MAT_IDENTITY: ent = (i == j) ? Q_ONE : '0;
          MAT_TINY: ent = q_t'(1);
          MAT_MAX: ent = Q_MAX;
          MAT_MIN: ent = Q_MIN;
          MAT_MIXED: begin
            case ((i + j) % 4)
              0: ent = Q_MAX;
              1: ent = Q_MIN;
              2: ent = '0;
              default: ent = '1;
            endcase
          end
          MAT_SCALE: ent = random_component();
          default: ent = q_t'($urandom);
        endcase
        staged[2*i + j/2][DATA_W*(j%2) +: DATA_W] = ent;
      end
    end
    for (int k = 0; k < NUM_REGS; k++) begin
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_index <= CFG_IDX_W'(k);
      cfg_data <= staged[k];
      matrix_regs[k] = staged[k];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // waits until every queued item is accepted and every result has come back, then the pipeline is left to empty
  task automatic drain_and_settle();
    int waited;
    waited = 0;
    while (accepted_count != queued_count) @(posedge clk);
    while (expected_vectors.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_vectors.size() != 0) begin
      flag_error($sformatf("%0d results never arrived", expected_vectors.size()));
      expected_vectors.delete();
    end
    repeat (LATENCY + 3) @(posedge clk);
  endtask

  always @(posedge clk) begin : driver
    vec_t next_vec;
    if (rst) begin
      start <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (start && !busy) begin
        expected_vectors.push_back(transform_vector({in_w, in_z, in_y, in_x}));
        accepted_count++;
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_vectors.size() > 0) begin
          next_vec = pending_vectors.pop_front();
          start <= 1'b1;
          in_x <= next_vec[0];
          in_y <= next_vec[1];
          in_z <= next_vec[2];
          in_w <= next_vec[3];
          if (bursty) begin
            if (burst_left <= 1) begin
              gap_left = $urandom_range(12, 1);
              burst_left = $urandom_range(16, 1);
            end else begin
              burst_left--;
            end
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    vec_t got;
    vec_t want;
    if (!rst && done) begin
      got = {out_w, out_z, out_y, out_x};
      if (expected_vectors.size() == 0) begin
        flag_error($sformatf("result with no item outstanding: %h", got));
      end else begin
        want = expected_vectors.pop_front();
        for (int i = 0; i < DIM; i++) begin
          if (got[i] !== want[i]) begin
            flag_error($sformatf("%s expected %h got %h", field_name[i], want[i], got[i]));
          end
        end
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // identity after reset
    bursty = 1'b0;
    queue_xyzw('0, '0, '0, '0);
    queue_xyzw(Q_MAX, Q_MAX, Q_MAX, Q_MAX);
    queue_xyzw(Q_MIN, Q_MIN, Q_MIN, Q_MIN);
    queue_xyzw(Q_MAX, Q_MIN, '1, Q_ONE);
    queue_xyzw('1, '1, '1, '1);
    queue_xyzw(q_t'(1), q_t'(2), q_t'(3), q_t'(4));
    drain_and_settle();

    // smallest entries: truncation toward minus infinity
    bursty = 1'b1;
    load_matrix(MAT_TINY);
    queue_xyzw(q_t'(1), q_t'(1), q_t'(1), q_t'(1));
    queue_xyzw('1, '0, '0, '0);
    queue_xyzw('1, '1, '1, '1);
    queue_xyzw(Q_MAX, Q_MIN, Q_MAX, Q_MIN);
    drain_and_settle();

    // saturation both ways
    load_matrix(MAT_MAX);
    queue_xyzw(Q_MAX, Q_MAX, Q_MAX, Q_MAX);
    queue_xyzw(Q_MIN, Q_MIN, Q_MIN, Q_MIN);
    queue_xyzw(Q_ONE, '0, '0, '0);
    queue_xyzw('1, '0, '0, '0);
    drain_and_settle();

    load_matrix(MAT_MIN);
    queue_xyzw(Q_MIN, Q_MIN, Q_MIN, Q_MIN);
    queue_xyzw(Q_MAX, Q_MAX, Q_MAX, Q_MAX);
    queue_xyzw(Q_ONE, Q_ONE, Q_ONE, Q_ONE);
    drain_and_settle();

    load_matrix(MAT_MIXED);
    queue_xyzw(Q_MAX, Q_MIN, '0, '1);
    queue_xyzw(Q_MIN, Q_MAX, '1, '0);
    queue_xyzw(Q_ONE, -Q_ONE, Q_ONE, -Q_ONE);
    drain_and_settle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      bursty = (p != 2 && p != 5);
      case (p)
        0: load_matrix(MAT_SCALE);
        1: load_matrix(MAT_RANDOM);
        2: load_matrix(MAT_IDENTITY);
        3: load_matrix(MAT_SCALE);
        4: load_matrix(MAT_MIXED);
        5: load_matrix(MAT_SCALE);
        6: load_matrix(MAT_TINY);
        default: load_matrix(MAT_RANDOM);
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        queue_xyzw(random_component(), random_component(),
                   random_component(), random_component());
      end
      drain_and_settle();
    end

    if (error_count == 0) begin
      $display("PASS matrix4_vector_transform");
    end else begin
      $display("FAIL matrix4_vector_transform");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL matrix4_vector_transform");
    $finish;
  end

endmodule
`default_nettype wire
